// ----- sv/hsv2rgb_pkg.sv -----
`default_nettype none
package hsv2rgb_pkg;

    // Field widths
    localparam int HUE_W   = 9;
    localparam int PCT_W   = 7;
    localparam int CHAN_W  = 8;
    localparam int GAIN_W  = 6;
    localparam int OFFS_W  = 6;
    localparam int SATP_W  = CHAN_W + PCT_W;   // (255 - c) * (100 - s)
    localparam int SCALE_W = CHAN_W + GAIN_W;  // c * gain
    localparam int RECIP_W = 13;
    localparam int QFULL_W = SATP_W + RECIP_W;

    // Pipeline depth: front stage plus four channel stages
    localparam int NUM_STAGES = 5;

    // Input limits
    localparam logic [HUE_W-1:0] HUE_LIMIT = 9'd360;
    localparam logic [HUE_W-1:0] HUE_MAX   = 9'd359;
    localparam logic [PCT_W-1:0] PCT_MAX   = 7'd100;

    // Sector bounds (first hue of the next sector)
    localparam logic [HUE_W-1:0] SEC0_END = 9'd61;
    localparam logic [HUE_W-1:0] SEC1_END = 9'd121;
    localparam logic [HUE_W-1:0] SEC2_END = 9'd181;
    localparam logic [HUE_W-1:0] SEC3_END = 9'd241;
    localparam logic [HUE_W-1:0] SEC4_END = 9'd301;

    // Sector base hues
    localparam logic [HUE_W-1:0] SEC1_BASE = 9'd60;
    localparam logic [HUE_W-1:0] SEC2_BASE = 9'd120;
    localparam logic [HUE_W-1:0] SEC3_BASE = 9'd180;
    localparam logic [HUE_W-1:0] SEC4_BASE = 9'd240;
    localparam logic [HUE_W-1:0] SEC5_BASE = 9'd300;

    localparam logic [CHAN_W-1:0] CHAN_FULL = 8'd255;
    localparam logic [CHAN_W-1:0] CHAN_OFF  = 8'd0;

    // x / 100 == (x * 5243) >> 19, exact for x < 2^15
    localparam logic [RECIP_W-1:0] RECIP_100   = 13'd5243;
    localparam int                 RECIP_SHIFT = 19;

    // floor(v^0.9) for v = 0..100
    localparam logic [GAIN_W-1:0] GAMMA_TAB [101] = '{
         6'd0,  6'd1,  6'd1,  6'd2,  6'd3,  6'd4,  6'd5,  6'd5,  6'd6,  6'd7,
         6'd7,  6'd8,  6'd9, 6'd10, 6'd10, 6'd11, 6'd12, 6'd12, 6'd13, 6'd14,
        6'd14, 6'd15, 6'd16, 6'd16, 6'd17, 6'd18, 6'd18, 6'd19, 6'd20, 6'd20,
        6'd21, 6'd21, 6'd22, 6'd23, 6'd23, 6'd24, 6'd25, 6'd25, 6'd26, 6'd27,
        6'd27, 6'd28, 6'd28, 6'd29, 6'd30, 6'd30, 6'd31, 6'd31, 6'd32, 6'd33,
        6'd33, 6'd34, 6'd35, 6'd35, 6'd36, 6'd36, 6'd37, 6'd38, 6'd38, 6'd39,
        6'd39, 6'd40, 6'd41, 6'd41, 6'd42, 6'd42, 6'd43, 6'd44, 6'd44, 6'd45,
        6'd45, 6'd46, 6'd46, 6'd47, 6'd48, 6'd48, 6'd49, 6'd49, 6'd50, 6'd51,
        6'd51, 6'd52, 6'd52, 6'd53, 6'd53, 6'd54, 6'd55, 6'd55, 6'd56, 6'd56,
        6'd57, 6'd57, 6'd58, 6'd59, 6'd59, 6'd60, 6'd60, 6'd61, 6'd61, 6'd62,
        6'd63
    };

    // Front stage result: raw channels plus shared scale terms
    typedef struct packed {
        logic [CHAN_W-1:0] red;
        logic [CHAN_W-1:0] green;
        logic [CHAN_W-1:0] blue;
        logic [PCT_W-1:0]  inv_sat;
        logic [GAIN_W-1:0] gain;
    } t_front;

    // Load enables for the channel stages
    typedef struct packed {
        logic s2;
        logic s3;
        logic s4;
        logic s5;
    } t_stage_en;

    // Divide a value below 2^15 by 100
    function automatic logic [CHAN_W-1:0] div100(input logic [SATP_W-1:0] x);
        logic [QFULL_W-1:0] prod;
        prod = QFULL_W'(x) * QFULL_W'(RECIP_100);
        return CHAN_W'(prod >> RECIP_SHIFT);
    endfunction

endpackage
`default_nettype wire

// ----- sv/hsv2rgb_in_if.sv -----
`default_nettype none
interface hsv2rgb_in_if;
    import hsv2rgb_pkg::*;

    logic             valid;
    logic             ready;
    logic [HUE_W-1:0] hue;
    logic [PCT_W-1:0] saturation;
    logic [PCT_W-1:0] brightness;

    modport source (output valid, output hue, output saturation, output brightness,
                    input ready);
    modport sink   (input valid, input hue, input saturation, input brightness,
                    output ready);
endinterface
`default_nettype wire

// ----- sv/hsv2rgb_out_if.sv -----
`default_nettype none
interface hsv2rgb_out_if;
    import hsv2rgb_pkg::*;

    logic              valid;
    logic              ready;
    logic [CHAN_W-1:0] red;
    logic [CHAN_W-1:0] green;
    logic [CHAN_W-1:0] blue;

    modport source (output valid, output red, output green, output blue, input ready);
    modport sink   (input valid, input red, input green, input blue, output ready);
endinterface
`default_nettype wire

// ----- sv/hsv2rgb_front.sv -----
`default_nettype none
module hsv2rgb_front (
    input  wire logic                     i_clk,
    input  wire logic                     i_en,
    input  wire logic [hsv2rgb_pkg::HUE_W-1:0] i_hue,
    input  wire logic [hsv2rgb_pkg::PCT_W-1:0] i_sat,
    input  wire logic [hsv2rgb_pkg::PCT_W-1:0] i_bright,
    output hsv2rgb_pkg::t_front           o_front
);
    import hsv2rgb_pkg::*;

    // Rising ramp: floor(17*d/4)
    function automatic logic [CHAN_W-1:0] ramp_up(input logic [OFFS_W-1:0] d);
        logic [10:0] x;
        x = 11'(d) * 11'd17;
        return x[9:2];
    endfunction

    // Falling ramp: 255 - ceil(17*d/4)
    function automatic logic [CHAN_W-1:0] ramp_down(input logic [OFFS_W-1:0] d);
        logic [10:0] x;
        x = 11'(d) * 11'd17 + 11'd3;
        return CHAN_FULL - x[9:2];
    endfunction

    logic [HUE_W-1:0] hue_c;
    logic [PCT_W-1:0] sat_c;
    logic [PCT_W-1:0] bright_c;
    t_front           n_front;
    t_front           r_front;

    // Clamp inputs
    assign hue_c    = (i_hue >= HUE_LIMIT) ? HUE_MAX : i_hue;
    assign sat_c    = (i_sat > PCT_MAX) ? PCT_MAX : i_sat;
    assign bright_c = (i_bright > PCT_MAX) ? PCT_MAX : i_bright;

    // Sector decode and ramp
    always_comb begin
        n_front.inv_sat = PCT_MAX - sat_c;
        n_front.gain    = GAMMA_TAB[bright_c];
        if (hue_c < SEC0_END) begin
            n_front.red   = CHAN_FULL;
            n_front.green = ramp_up(OFFS_W'(hue_c));
            n_front.blue  = CHAN_OFF;
        end else if (hue_c < SEC1_END) begin
            n_front.red   = ramp_down(OFFS_W'(hue_c - SEC1_BASE));
            n_front.green = CHAN_FULL;
            n_front.blue  = CHAN_OFF;
        end else if (hue_c < SEC2_END) begin
            n_front.red   = CHAN_OFF;
            n_front.green = CHAN_FULL;
            n_front.blue  = ramp_up(OFFS_W'(hue_c - SEC2_BASE));
        end else if (hue_c < SEC3_END) begin
            n_front.red   = CHAN_OFF;
            n_front.green = ramp_down(OFFS_W'(hue_c - SEC3_BASE));
            n_front.blue  = CHAN_FULL;
        end else if (hue_c < SEC4_END) begin
            n_front.red   = ramp_up(OFFS_W'(hue_c - SEC4_BASE));
            n_front.green = CHAN_OFF;
            n_front.blue  = CHAN_FULL;
        end else begin
            n_front.red   = CHAN_FULL;
            n_front.green = CHAN_OFF;
            n_front.blue  = ramp_down(OFFS_W'(hue_c - SEC5_BASE));
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_front <= n_front;
        end
    end

    assign o_front = r_front;
endmodule
`default_nettype wire

// ----- sv/hsv2rgb_chan.sv -----
`default_nettype none
module hsv2rgb_chan (
    input  wire logic                          i_clk,
    input  wire hsv2rgb_pkg::t_stage_en        i_en,
    input  wire logic [hsv2rgb_pkg::CHAN_W-1:0] i_chan,
    input  wire logic [hsv2rgb_pkg::PCT_W-1:0]  i_inv_sat,
    input  wire logic [hsv2rgb_pkg::GAIN_W-1:0] i_gain,
    output logic      [hsv2rgb_pkg::CHAN_W-1:0] o_chan
);
    import hsv2rgb_pkg::*;

    logic [CHAN_W-1:0]  r_c2;
    logic [SATP_W-1:0]  r_p2;
    logic [GAIN_W-1:0]  r_g2;
    logic [CHAN_W-1:0]  r_c3;
    logic [GAIN_W-1:0]  r_g3;
    logic [SCALE_W-1:0] r_m4;
    logic [CHAN_W-1:0]  r_o5;

    logic [CHAN_W-1:0]  comp;
    logic [CHAN_W:0]    n_c3;

    assign comp = CHAN_FULL - i_chan;
    assign n_c3 = {1'b0, r_c2} + {1'b0, div100(r_p2)};

    // Stage 2: distance to full times (100 - s)
    always_ff @(posedge i_clk) begin
        if (i_en.s2) begin
            r_c2 <= i_chan;
            r_p2 <= SATP_W'(comp) * SATP_W'(i_inv_sat);
            r_g2 <= i_gain;
        end
    end

    // Stage 3: add the saturation blend (never exceeds 255)
    always_ff @(posedge i_clk) begin
        if (i_en.s3) begin
            r_c3 <= n_c3[CHAN_W-1:0];
            r_g3 <= r_g2;
        end
    end

    // Stage 4: brightness product
    always_ff @(posedge i_clk) begin
        if (i_en.s4) begin
            r_m4 <= SCALE_W'(r_c3) * SCALE_W'(r_g3);
        end
    end

    // Stage 5: divide by 100 into the output register
    always_ff @(posedge i_clk) begin
        if (i_en.s5) begin
            r_o5 <= div100(SATP_W'(r_m4));
        end
    end

    assign o_chan = r_o5;
endmodule
`default_nettype wire

// ----- sv/hsv_to_rgb_color.sv -----
// HSV to RGB color converter, one color per clock while o_rgb.ready is high.
//
// i_hsv (sink) takes hue in degrees and saturation and brightness in
// percent; o_rgb (source) gives 8-bit red, green and blue. Both use a
// valid/ready handshake; an item moves at a clock edge where both are high.
// Out-of-range inputs are clamped (hue to 359, percentages to 100).
//
// The pipeline has 5 register stages (clamp/sector/ramp, saturation product,
// blend, brightness product, divide into the output register); a result
// reaches o_rgb once its item has passed all five. It takes one item per
// cycle when nothing stalls.
//
// Each stage carries a valid bit and loads when it is empty or the stage
// after it moves. When the receiver holds o_rgb.ready low the output stays
// put, the stages behind it fill up, and i_hsv.ready drops only once all
// five stages hold items. Nothing is lost or repeated.
// Synchronous active-low reset empties the pipeline; data registers are
// not reset.
`default_nettype none
module hsv_to_rgb_color (
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    hsv2rgb_in_if.sink    i_hsv,
    hsv2rgb_out_if.source o_rgb
);
    import hsv2rgb_pkg::*;

    logic [NUM_STAGES:1] r_v;
    logic [NUM_STAGES:1] n_v;
    logic [NUM_STAGES:1] en;
    t_front              front;
    t_stage_en           chan_en;

    // Stage load enables, back from the output
    always_comb begin
        en[NUM_STAGES] = !r_v[NUM_STAGES] || o_rgb.ready;
        for (int k = NUM_STAGES - 1; k >= 1; k--) begin
            en[k] = !r_v[k] || en[k+1];
        end
    end

    // Valid bits travel with the data
    always_comb begin
        n_v = r_v;
        if (en[1]) begin
            n_v[1] = i_hsv.valid;
        end
        for (int k = 2; k <= NUM_STAGES; k++) begin
            if (en[k]) begin
                n_v[k] = r_v[k-1];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else begin
            r_v <= n_v;
        end
    end

    assign chan_en.s2 = en[2];
    assign chan_en.s3 = en[3];
    assign chan_en.s4 = en[4];
    assign chan_en.s5 = en[5];

    hsv2rgb_front u_front (
        .i_clk    (i_clk),
        .i_en     (en[1]),
        .i_hue    (i_hsv.hue),
        .i_sat    (i_hsv.saturation),
        .i_bright (i_hsv.brightness),
        .o_front  (front)
    );

    hsv2rgb_chan u_red (
        .i_clk     (i_clk),
        .i_en      (chan_en),
        .i_chan    (front.red),
        .i_inv_sat (front.inv_sat),
        .i_gain    (front.gain),
        .o_chan    (o_rgb.red)
    );

    hsv2rgb_chan u_green (
        .i_clk     (i_clk),
        .i_en      (chan_en),
        .i_chan    (front.green),
        .i_inv_sat (front.inv_sat),
        .i_gain    (front.gain),
        .o_chan    (o_rgb.green)
    );

    hsv2rgb_chan u_blue (
        .i_clk     (i_clk),
        .i_en      (chan_en),
        .i_chan    (front.blue),
        .i_inv_sat (front.inv_sat),
        .i_gain    (front.gain),
        .o_chan    (o_rgb.blue)
    );

    assign i_hsv.ready = en[1];
    assign o_rgb.valid = r_v[NUM_STAGES];
endmodule
`default_nettype wire

// ----- sv/hsv2rgb_chk.sv -----
`default_nettype none
module hsv2rgb_chk (
    input wire logic                           i_clk,
    input wire logic                           i_rst_n,
    input wire logic                           i_in_valid,
    input wire logic                           i_in_ready,
    input wire logic [hsv2rgb_pkg::PCT_W-1:0]  i_bright,
    input wire logic                           i_out_valid,
    input wire logic                           i_out_ready,
    input wire logic [hsv2rgb_pkg::CHAN_W-1:0] i_red,
    input wire logic [hsv2rgb_pkg::CHAN_W-1:0] i_green,
    input wire logic [hsv2rgb_pkg::CHAN_W-1:0] i_blue
);
    import hsv2rgb_pkg::*;

    // A stalled result stays valid
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid)
        else $error("output item dropped while stalled");

    // A stalled result keeps its color
    a_out_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> $stable(i_red) && $stable(i_green) && $stable(i_blue))
        else $error("output item changed while stalled");

    // Input back-pressure only comes from a stalled output
    a_ready_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_in_ready |-> i_out_valid && !i_out_ready)
        else $error("input stalled without output stall");

    // Zero brightness gives black when nothing stalls
    a_black: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && i_in_ready && i_bright == '0)
            ##1 i_out_ready ##1 i_out_ready ##1 i_out_ready ##1 i_out_ready
        |=> i_out_valid && i_red == '0 && i_green == '0 && i_blue == '0)
        else $error("zero brightness did not give black");
endmodule

bind hsv_to_rgb_color hsv2rgb_chk u_chk (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_hsv.valid),
    .i_in_ready  (i_hsv.ready),
    .i_bright    (i_hsv.brightness),
    .i_out_valid (o_rgb.valid),
    .i_out_ready (o_rgb.ready),
    .i_red       (o_rgb.red),
    .i_green     (o_rgb.green),
    .i_blue      (o_rgb.blue)
);
`default_nettype wire
